>>> hw/rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// ARP cache package
// Table depth, operation and status codes, controller states and commands.
// ----------------------------------------------------------------------------
`default_nettype none

package arpc_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);

	localparam logic signed [10:0] HANDLE_NONE = -11'sd1;

	typedef enum logic [2:0] {
		OP_INSERT     = 3'd0,
		OP_LOOKUP     = 3'd1,
		OP_REM_HANDLE = 3'd2,
		OP_REM_IP     = 3'd3,
		OP_CLEAR      = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_UPDATED   = 3'd1,
		ST_DONE      = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CTL_IDLE,
		CTL_LOOKUP,
		CTL_UPDATE
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic lookup;
		logic update;
	} arpc_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/arpc_ctrl.sv
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences load, lookup and update of each item and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_ctrl
	import arpc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	output arpc_cmd_t  cmd
);

	ctl_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CTL_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd        = '0;
		case (state_q)
			CTL_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = CTL_LOOKUP;
				end
			end
			CTL_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = CTL_UPDATE;
			end
			CTL_UPDATE: begin
				if (!out_valid_q || m_tready) begin
					cmd.update = 1'b1;
					s_tready   = 1'b1;
					if (s_tvalid) begin
						cmd.load = 1'b1;
						state_d  = CTL_LOOKUP;
					end else begin
						state_d = CTL_IDLE;
					end
				end
			end
			default: begin
				state_d = CTL_IDLE;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/arpc_dpath.sv
// ----------------------------------------------------------------------------
// ARP cache datapath
// Entry table, parallel match, age ranks and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module arpc_dpath
	import arpc_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire arpc_cmd_t           cmd,
	input  wire logic [2:0]          in_operation,
	input  wire logic [31:0]         in_ip,
	input  wire logic [47:0]         in_mac,
	input  wire logic signed [10:0]  in_handle,
	input  wire logic                in_delete,
	output logic [2:0]               out_status,
	output logic [47:0]              out_mac,
	output logic signed [10:0]       out_handle
);

	logic [2:0]          op_q;
	logic [31:0]         ip_q;
	logic [47:0]         mac_q;
	logic signed [10:0]  hdl_q;
	logic                del_q;

	logic [ENTRIES-1:0]  valid_q;
	logic [IDX_W-1:0]    rank_q  [ENTRIES];
	logic [31:0]         ip_mem  [ENTRIES];
	logic [47:0]         mac_mem [ENTRIES];
	logic signed [10:0]  hdl_mem [ENTRIES];

	logic [ENTRIES-1:0]  ip_hit, hdl_hit, hdl_best, free_vec, free_first;
	logic [ENTRIES-1:0]  hit_s1, free_s1;
	logic                found_s1, full_s1;

	logic [IDX_W-1:0]    hit_rank;
	logic [47:0]         hit_mac;
	logic signed [10:0]  hit_hdl;
	logic                do_insert, do_drop, do_detach, do_refresh, do_clear;
	logic [2:0]          status_d;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_operation;
			ip_q  <= in_ip;
			mac_q <= in_mac;
			hdl_q <= in_handle;
			del_q <= in_delete;
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			ip_hit[i]  = valid_q[i] && (ip_mem[i] == ip_q);
			hdl_hit[i] = valid_q[i] && (hdl_mem[i] == hdl_q);
		end
		for (int i = 0; i < ENTRIES; i++) begin
			hdl_best[i] = hdl_hit[i];
			for (int j = 0; j < ENTRIES; j++) begin
				if (hdl_hit[j] && (rank_q[j] < rank_q[i])) begin
					hdl_best[i] = 1'b0;
				end
			end
		end
		free_vec   = ~valid_q;
		free_first = free_vec & (~free_vec + ENTRIES'(1));
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			hit_s1   <= (op_q == OP_REM_HANDLE) ? hdl_best : ip_hit;
			found_s1 <= (op_q == OP_REM_HANDLE) ? (|hdl_best) : (|ip_hit);
			free_s1  <= free_first;
			full_s1  <= &valid_q;
		end
	end

	always_comb begin
		hit_rank = '0;
		hit_mac  = '0;
		hit_hdl  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_s1[i]) begin
				hit_rank = hit_rank | rank_q[i];
				hit_mac  = hit_mac | mac_mem[i];
				hit_hdl  = hit_hdl | hdl_mem[i];
			end
		end
	end

	always_comb begin
		do_insert  = 1'b0;
		do_drop    = 1'b0;
		do_detach  = 1'b0;
		do_refresh = 1'b0;
		do_clear   = 1'b0;
		status_d   = ST_NOT_FOUND;
		case (op_q)
			OP_INSERT: begin
				if (found_s1) begin
					do_refresh = 1'b1;
					status_d   = ST_UPDATED;
				end else if (full_s1) begin
					status_d = ST_FULL;
				end else begin
					do_insert = 1'b1;
					status_d  = ST_INSERTED;
				end
			end
			OP_LOOKUP: begin
				if (found_s1) begin
					status_d = ST_DONE;
				end
			end
			OP_REM_HANDLE: begin
				if (found_s1) begin
					do_drop   = del_q;
					do_detach = !del_q;
					status_d  = ST_DONE;
				end
			end
			OP_REM_IP: begin
				if (found_s1) begin
					do_drop  = 1'b1;
					status_d = ST_DONE;
				end
			end
			OP_CLEAR: begin
				do_clear = 1'b1;
				status_d = ST_DONE;
			end
			default: begin
				status_d = ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (cmd.update) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (do_clear) begin
					valid_q[i] <= 1'b0;
					rank_q[i]  <= '0;
				end else if (do_insert) begin
					if (free_s1[i]) begin
						valid_q[i] <= 1'b1;
						rank_q[i]  <= '0;
					end else if (valid_q[i]) begin
						rank_q[i] <= rank_q[i] + IDX_W'(1);
					end
				end else if (do_drop) begin
					if (hit_s1[i]) begin
						valid_q[i] <= 1'b0;
						rank_q[i]  <= '0;
					end else if (valid_q[i] && (rank_q[i] > hit_rank)) begin
						rank_q[i] <= rank_q[i] - IDX_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (do_insert && free_s1[i]) begin
					ip_mem[i]  <= ip_q;
					mac_mem[i] <= mac_q;
					hdl_mem[i] <= hdl_q;
				end
				if (do_refresh && hit_s1[i]) begin
					mac_mem[i] <= mac_q;
				end
				if (do_detach && hit_s1[i]) begin
					hdl_mem[i] <= HANDLE_NONE;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_status <= status_d;
			if ((op_q == OP_LOOKUP) && found_s1) begin
				out_mac    <= hit_mac;
				out_handle <= hit_hdl;
			end else begin
				out_mac    <= '0;
				out_handle <= HANDLE_NONE;
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/arp_cache_table.sv
// ----------------------------------------------------------------------------
// ARP cache table
// IPv4 to MAC resolution cache with insert, lookup, remove and clear.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                         tuser
//  s_*      in   ip[31:0] mac[79:32] handle[90:80] delete[91]  operation[2:0]
//  m_*      out  mac[47:0] handle[58:48]                       status[2:0]
//
//  An item passes through a lookup step, the parallel compare over all entries,
//  and an update step, the table update and the result register write.
//  A new item is taken in the update cycle of the one before it.
//  A result waiting in the output register stalls only the update cycle.
//  Reset empties the table at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cache_table
	import arpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [95:0] s_tdata,   // ip_address, mac_address, client_handle, delete_entry
	input  wire logic [2:0]  s_tuser,   // operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // found_mac, found_handle
	output logic [2:0]       m_tuser    // status
);

	arpc_cmd_t          cmd;
	logic [47:0]        res_mac;
	logic signed [10:0] res_handle;

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	arpc_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.in_operation (s_tuser),
		.in_ip        (s_tdata[31:0]),
		.in_mac       (s_tdata[79:32]),
		.in_handle    (s_tdata[90:80]),
		.in_delete    (s_tdata[91]),
		.out_status   (m_tuser),
		.out_mac      (res_mac),
		.out_handle   (res_handle)
	);

	assign m_tdata = {5'd0, res_handle, res_mac};

endmodule

`default_nettype wire

>>> test/arp_cache_checker.sv
// ----------------------------------------------------------------------------
// ARP cache table checker
// Watches both stream channels, predicts the reply to every accepted request
// from a private copy of the table and compares each reply field by field.
// ----------------------------------------------------------------------------
module arp_cache_checker
	import arpc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [95:0] s_tdata,   // ip_address, mac_address, client_handle, delete_entry
	input  wire logic [2:0]  s_tuser,   // operation
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [63:0] m_tdata,   // found_mac, found_handle
	input  wire logic [2:0]  m_tuser,   // status
	output int               mismatches,
	output int               outstanding
);

	typedef struct packed {
		logic [2:0]  status;
		logic [47:0] mac;
		logic [10:0] handle;
	} reply_t;

	logic        slot_used   [ENTRIES];
	logic [31:0] slot_ip     [ENTRIES];
	logic [47:0] slot_mac    [ENTRIES];
	logic [10:0] slot_handle [ENTRIES];
	int          slot_rank   [ENTRIES];

	reply_t reply_q [$];
	reply_t got_reply;
	reply_t want_reply;
	int     fail_total;

	initial begin
		fail_total = 0;
		mismatches = 0;
		outstanding = 0;
		foreach (slot_used[k]) begin
			slot_used[k] = 1'b0;
			slot_rank[k] = 0;
		end
	end

	// drop a slot and close the gap in the age order
	task automatic evict_slot(input int s);
		int r;
		r = slot_rank[s];
		slot_used[s] = 1'b0;
		slot_rank[s] = 0;
		foreach (slot_used[k])
			if (slot_used[k] && slot_rank[k] > r)
				slot_rank[k]--;
	endtask

	task automatic predict_reply(
		input  logic [2:0]  op,
		input  logic [31:0] ip,
		input  logic [47:0] mac,
		input  logic [10:0] hnd,
		input  logic        del,
		output reply_t      r
	);
		int hit;
		int free;
		int pick;
		hit = -1;
		free = -1;
		pick = -1;
		r.status = ST_NOT_FOUND;
		r.mac = '0;
		r.handle = HANDLE_NONE;
		foreach (slot_used[k]) begin
			if (slot_used[k] && slot_ip[k] == ip && hit < 0)
				hit = k;
			if (!slot_used[k] && free < 0)
				free = k;
			if (slot_used[k] && slot_handle[k] == hnd &&
			    (pick < 0 || slot_rank[k] < slot_rank[pick]))
				pick = k;
		end
		case (op)
			OP_INSERT: begin
				if (hit >= 0) begin
					slot_mac[hit] = mac;
					r.status = ST_UPDATED;
				end else if (free < 0) begin
					r.status = ST_FULL;
				end else begin
					foreach (slot_used[k])
						if (slot_used[k])
							slot_rank[k]++;
					slot_used[free] = 1'b1;
					slot_ip[free] = ip;
					slot_mac[free] = mac;
					slot_handle[free] = hnd;
					slot_rank[free] = 0;
					r.status = ST_INSERTED;
				end
			end
			OP_LOOKUP: begin
				if (hit >= 0) begin
					r.status = ST_DONE;
					r.mac = slot_mac[hit];
					r.handle = slot_handle[hit];
				end
			end
			OP_REM_HANDLE: begin
				if (pick >= 0) begin
					if (del)
						evict_slot(pick);
					else
						slot_handle[pick] = HANDLE_NONE;
					r.status = ST_DONE;
				end
			end
			OP_REM_IP: begin
				if (hit >= 0) begin
					evict_slot(hit);
					r.status = ST_DONE;
				end
			end
			OP_CLEAR: begin
				foreach (slot_used[k]) begin
					slot_used[k] = 1'b0;
					slot_rank[k] = 0;
				end
				r.status = ST_DONE;
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got_reply.status = m_tuser;
				got_reply.mac = m_tdata[47:0];
				got_reply.handle = m_tdata[58:48];
				if (reply_q.size() == 0) begin
					$error("reply with none pending: status %0d", got_reply.status);
					fail_total++;
				end else begin
					want_reply = reply_q.pop_front();
					if (got_reply.status !== want_reply.status) begin
						$error("status: expected %0d, got %0d",
							want_reply.status, got_reply.status);
						fail_total++;
					end
					if (got_reply.mac !== want_reply.mac) begin
						$error("found_mac: expected %h, got %h",
							want_reply.mac, got_reply.mac);
						fail_total++;
					end
					if (got_reply.handle !== want_reply.handle) begin
						$error("found_handle: expected %0d, got %0d",
							$signed(want_reply.handle), $signed(got_reply.handle));
						fail_total++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				predict_reply(s_tuser, s_tdata[31:0], s_tdata[79:32], s_tdata[90:80],
					s_tdata[91], want_reply);
				reply_q.push_back(want_reply);
			end
			outstanding <= reply_q.size();
			mismatches <= fail_total;
		end
	end

endmodule

>>> test/tb_arp_cache_table.sv
// ----------------------------------------------------------------------------
// ARP cache table testbench
// Drives directed and random table requests under varying back-pressure and
// gives the verdict from the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
module tb_arp_cache_table;
	import arpc_pkg::*;

	localparam int         CYCLE_LIMIT  = 200000;
	localparam int         TAIL_CYCLES  = 8;
	localparam int         RANDOM_ITEMS = 1330;
	localparam int         POOL_SIZE    = 24;
	localparam logic [2:0] OP_SPARE_LO  = 3'd5;
	localparam logic [2:0] OP_SPARE_HI  = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;
	logic [2:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;

	int          mismatches;
	int          outstanding;
	int          cycles = 0;
	int          idle_pct;
	int          stall_pct;
	logic [31:0] ip_pool [POOL_SIZE];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	arp_cache_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	arp_cache_checker arp_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("[arp_cache_table] ERROR");
			$finish;
		end
	end

	task automatic send_request(
		input logic [2:0]  op,
		input logic [31:0] ip,
		input logic [47:0] mac,
		input logic [10:0] hnd,
		input logic        del
	);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, del, hnd, mac, ip};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin
		int          pick;
		logic [2:0]  op;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [10:0] hnd;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_INSERT;
		m_tready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		foreach (ip_pool[k])
			ip_pool[k] = $urandom;
		ip_pool[0] = '0;
		ip_pool[1] = '1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		send_request(OP_LOOKUP, 32'h0A00_0001, '0, 11'sd3, 1'b0);
		send_request(OP_REM_IP, 32'h0A00_0001, '0, 11'sd3, 1'b0);
		send_request(OP_REM_HANDLE, 32'h0A00_0001, '0, 11'sd3, 1'b1);
		// field extremes, then update of a present address
		send_request(OP_INSERT, '0, '0, 11'sd0, 1'b0);
		send_request(OP_INSERT, '1, '1, 11'sd1023, 1'b1);
		send_request(OP_INSERT, '0, '1, 11'sd5, 1'b0);
		send_request(OP_LOOKUP, '0, '0, 11'sd0, 1'b0);
		send_request(OP_LOOKUP, '1, '0, 11'sd0, 1'b0);
		// newest match by handle, detach, delete of the newest entry, then remove by address, spare op codes and clear
		send_request(OP_INSERT, 32'h0A00_0001, 48'h0200_0000_0001, HANDLE_NONE, 1'b0);
		send_request(OP_INSERT, 32'h0A00_0002, 48'h0200_0000_0002, 11'sd7, 1'b0);
		send_request(OP_INSERT, 32'h0A00_0003, 48'h0200_0000_0003, 11'sd7, 1'b0);
		send_request(OP_REM_HANDLE, '0, '0, 11'sd7, 1'b0);
		send_request(OP_LOOKUP, 32'h0A00_0003, '0, 11'sd0, 1'b0);
		send_request(OP_REM_HANDLE, '0, '0, HANDLE_NONE, 1'b1);
		send_request(OP_LOOKUP, 32'h0A00_0003, '0, 11'sd0, 1'b0);
		send_request(OP_LOOKUP, 32'h0A00_0002, '0, 11'sd0, 1'b0);
		send_request(OP_LOOKUP, 32'h0A00_0001, '0, 11'sd0, 1'b0);
		send_request(OP_REM_IP, '1, '0, 11'sd0, 1'b0);
		send_request(OP_LOOKUP, '1, '0, 11'sd0, 1'b0);
		send_request(OP_SPARE_LO, '0, '0, 11'sd0, 1'b0);
		send_request(OP_SPARE_HI, '1, '1, HANDLE_NONE, 1'b1);
		send_request(OP_CLEAR, '0, '0, 11'sd0, 1'b0);
		send_request(OP_LOOKUP, '0, '0, 11'sd0, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ((i * 4) / RANDOM_ITEMS)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 82;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 82;
				end
				default: begin
					idle_pct = 23;
					stall_pct = 23;
				end
			endcase
			ip = ($urandom_range(99) < 85) ? ip_pool[$urandom_range(POOL_SIZE - 1)] : $urandom;
			mac = {16'($urandom), 32'($urandom)};
			pick = $urandom_range(99);
			if (pick < 15)
				hnd = HANDLE_NONE;
			else if (pick < 75)
				hnd = 11'($urandom_range(1, 6));
			else
				hnd = 11'($urandom_range(1023));
			pick = $urandom_range(99);
			if (pick < 45)
				op = OP_INSERT;
			else if (pick < 68)
				op = OP_LOOKUP;
			else if (pick < 78)
				op = OP_REM_HANDLE;
			else if (pick < 88)
				op = OP_REM_IP;
			else if (pick < 89)
				op = OP_CLEAR;
			else if (pick < 91)
				op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			else
				op = OP_INSERT;
			send_request(op, ip, mac, hnd, 1'($urandom_range(1)));
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (outstanding != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("[arp_cache_table] OK");
		else
			$display("[arp_cache_table] ERROR");
		$finish;
	end

endmodule

>>> arp_cache_table.f
hw/rtl/arpc_pkg.sv
hw/rtl/arpc_ctrl.sv
hw/rtl/arpc_dpath.sv
hw/rtl/arp_cache_table.sv
test/arp_cache_checker.sv
test/tb_arp_cache_table.sv
